@@ rtl/btds_pkg.sv @@
// ----------------------------------------------------------------------------
// btds_pkg
// Shared types and constants of the byte translate, delete and squeeze block.
// ----------------------------------------------------------------------------
package btds_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DELETE_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_MODE = 1'd1;

  // Request types of an input item.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DATA = 1'b1;

  // One translation table entry.
  typedef struct packed {
    logic [BYTE_W-1:0] map;
    logic              sel;
  } entry_t;

  // Write request into the translation table.
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] idx;
    entry_t            entry;
  } tbl_wr_t;

  // Read request into the translation table.
  typedef struct packed {
    logic              en;
    logic [BYTE_W-1:0] addr;
  } tbl_rd_t;

endpackage

@@ rtl/btds_if.sv @@
// ----------------------------------------------------------------------------
// btds_in_if / btds_out_if
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface btds_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [7:0] entry_map;
  logic       entry_selected;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (
    output valid, req_type, entry_index, entry_map, entry_selected, byte_in, last_in,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, entry_map, entry_selected, byte_in, last_in,
    output ready
  );
endinterface

interface btds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       byte_present;
  logic       line_end;

  modport source (
    output valid, byte_out, byte_present, line_end,
    input  ready
  );
  modport sink (
    input  valid, byte_out, byte_present, line_end,
    output ready
  );
endinterface

@@ rtl/btds_table.sv @@
// ----------------------------------------------------------------------------
// btds_table
// 256-entry translation table with one write and one registered read port.
// ----------------------------------------------------------------------------
module btds_table (
  input  logic             clk,
  input  logic             rst_n,
  input  btds_pkg::tbl_wr_t wr,
  input  btds_pkg::tbl_rd_t rd,
  output btds_pkg::entry_t  rd_entry
);

  btds_pkg::entry_t                        mem_r [btds_pkg::TABLE_DEPTH];
  logic [btds_pkg::TABLE_DEPTH-1:0]        valid_r;
  btds_pkg::entry_t                        rd_data_r;
  logic                                    rd_valid_r;
  logic [btds_pkg::BYTE_W-1:0]             rd_addr_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.entry;
    end
    if (rd.en) begin
      rd_data_r <= mem_r[rd.addr];
      rd_addr_r <= rd.addr;
    end
  end

  // Entries never written since reset read as the identity mapping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd.en) begin
        rd_valid_r <= valid_r[rd.addr];
      end
    end
  end

  always_comb begin
    if (rd_valid_r) begin
      rd_entry = rd_data_r;
    end else begin
      rd_entry.map = rd_addr_r;
      rd_entry.sel = 1'b0;
    end
  end

endmodule

@@ rtl/byte_translate_delete_squeeze.sv @@
// ----------------------------------------------------------------------------
// byte_translate_delete_squeeze
// Streams line bytes through a loadable translation table with delete and
// squeeze modes.
//
// Input items arrive on in_if. An item with req_type REQ_LOAD writes one table
// entry and gives no result. An item with req_type REQ_DATA carries one byte of
// a line; last_in marks the final byte. Each kept byte gives one result item on
// out_if, and a line end whose byte was dropped gives a bare result with
// byte_present low and byte_out zero. The two mode registers are written over
// the cfg_ port; the user must do so only while the block is idle, which the
// block itself does not enforce. The block takes one item per cycle while
// the receiver does not stall. A data byte reads the table at the clock edge
// that accepts it and waits in the read stage until the output register has
// room; its result is then registered there and drives out_if.valid.
// The single table read port sets the rate of one item per cycle.
// Reset empties the pipeline, clears the modes and the line state, and makes
// every table entry read as the identity mapping with its selected bit low at
// once; there is no clearing pass. When the receiver stalls, the output
// register and one byte in the read stage hold, which takes in_if.ready low.
// ----------------------------------------------------------------------------
module byte_translate_delete_squeeze (
  input  logic                                 clk,
  input  logic                                 rst_n,
  btds_in_if.sink                              in_if,
  btds_out_if.source                           out_if,
  input  logic                                 cfg_we,
  input  logic [btds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [btds_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // Mode registers.
  logic delete_mode_r;
  logic squeeze_mode_r;

  // Read stage: a data byte whose table entry is being read.
  logic                        s1_valid_r, s1_valid_nxt;
  logic [btds_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        s1_last_r;

  // Line state used for squeezing.
  logic                        have_prev_r, have_prev_nxt;
  logic [btds_pkg::BYTE_W-1:0] prev_kept_r, prev_kept_nxt;

  // Output register.
  logic                        out_valid_r, out_valid_nxt;
  logic [btds_pkg::BYTE_W-1:0] out_byte_r;
  logic                        out_present_r;
  logic                        out_line_end_r;

  logic                        in_fire;
  logic                        s1_adv;
  logic                        s1_fire;
  logic                        emit;
  logic                        drop;
  logic [btds_pkg::BYTE_W-1:0] res;
  btds_pkg::entry_t            rd_entry;
  btds_pkg::tbl_wr_t           tbl_wr;
  btds_pkg::tbl_rd_t           tbl_rd;

  // The read stage may move on whenever the output register has room.
  assign s1_adv      = !out_valid_r || out_if.ready;
  assign s1_fire     = s1_valid_r && s1_adv;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  // A load writes its entry at the accepting edge, so a byte accepted in
  // the next cycle already reads the new contents.
  always_comb begin
    tbl_wr.en        = in_fire && (in_if.req_type == btds_pkg::REQ_LOAD);
    tbl_wr.idx       = in_if.entry_index;
    tbl_wr.entry.map = in_if.entry_map;
    tbl_wr.entry.sel = in_if.entry_selected;
    tbl_rd.en        = in_fire && (in_if.req_type == btds_pkg::REQ_DATA);
    tbl_rd.addr      = in_if.byte_in;
  end

  btds_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd       (tbl_rd),
    .rd_entry (rd_entry)
  );

  // Translate, then decide whether the byte is dropped.
  always_comb begin
    if (delete_mode_r) begin
      res  = s1_byte_r;
      drop = rd_entry.sel;
    end else begin
      res  = rd_entry.sel ? rd_entry.map : s1_byte_r;
      drop = squeeze_mode_r && rd_entry.sel && have_prev_r && (prev_kept_r == res);
    end
    emit = !drop || s1_last_r;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_if.ready) begin
      s1_valid_nxt = tbl_rd.en;
    end

    have_prev_nxt = have_prev_r;
    prev_kept_nxt = prev_kept_r;
    if (s1_fire) begin
      if (s1_last_r) begin
        // A line end closes the line: squeezing never reaches across lines.
        have_prev_nxt = 1'b0;
        prev_kept_nxt = '0;
      end else if (!drop) begin
        have_prev_nxt = 1'b1;
        prev_kept_nxt = res;
      end
    end

    out_valid_nxt = out_valid_r;
    if (s1_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      have_prev_r    <= 1'b0;
      prev_kept_r    <= '0;
      out_valid_r    <= 1'b0;
      delete_mode_r  <= 1'b0;
      squeeze_mode_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      have_prev_r <= have_prev_nxt;
      prev_kept_r <= prev_kept_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          btds_pkg::REG_DELETE_MODE:  delete_mode_r  <= cfg_wdata[0];
          btds_pkg::REG_SQUEEZE_MODE: squeeze_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (tbl_rd.en) begin
      s1_byte_r <= in_if.byte_in;
      s1_last_r <= in_if.last_in;
    end
    if (s1_fire && emit) begin
      out_byte_r     <= drop ? '0 : res;
      out_present_r  <= !drop;
      out_line_end_r <= s1_last_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.byte_out     = out_byte_r;
  assign out_if.byte_present = out_present_r;
  assign out_if.line_end     = out_line_end_r;

`ifndef ASSERT_OFF
  // An accepted data byte always occupies the read stage next cycle.
  a_data_enters_s1: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_rd.en |=> s1_valid_r)
    else $error("accepted data byte did not reach the read stage");

  // A byte held in the read stage is neither lost nor overwritten.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(s1_last_r)))
    else $error("stalled read stage changed");

  // A bare result only closes a line and carries a zero byte.
  a_bare_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_present_r) |-> (out_line_end_r && (out_byte_r == '0)))
    else $error("bare result without line end or with nonzero byte");

  // The line state is cleared after every line end.
  a_line_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (!have_prev_r && (prev_kept_r == '0)))
    else $error("line state not cleared at line end");
`endif

endmodule

@@ verif/btds_result_compare.sv @@
// ----------------------------------------------------------------------------
// btds_result_compare
// Watches the input, result and mode-register traffic of the translate,
// delete and squeeze block. It keeps its own copy of the translation table,
// the modes and the line state, predicts the result item of every accepted
// data byte that gives one, and compares accepted results in order.
// ----------------------------------------------------------------------------
module btds_result_compare (
  input  logic                            clk,
  input  logic                            rst_n,
  btds_in_if                              in_mon,
  btds_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [btds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [btds_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic [btds_pkg::BYTE_W-1:0] byte_out;
    logic                        byte_present;
    logic                        line_end;
  } line_result_t;

  logic [btds_pkg::BYTE_W-1:0] map_copy [btds_pkg::TABLE_DEPTH];
  logic                        sel_copy [btds_pkg::TABLE_DEPTH];
  logic [btds_pkg::BYTE_W-1:0] prev_kept;
  logic                        have_prev;
  logic                        delete_on;
  logic                        squeeze_on;

  line_result_t      line_results_q [$];

  always @(posedge clk) begin : transliterate
    int                          i;
    logic [btds_pkg::BYTE_W-1:0] res;
    logic                        drop;
    line_result_t                want;
    line_result_t                got;

    if (!rst_n) begin
      for (i = 0; i < btds_pkg::TABLE_DEPTH; i++) begin
        map_copy[i] = i[btds_pkg::BYTE_W-1:0];
        sel_copy[i] = 1'b0;
      end
      prev_kept  = '0;
      have_prev  = 1'b0;
      delete_on  = 1'b0;
      squeeze_on = 1'b0;
      mismatches = 0;
      line_results_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          btds_pkg::REG_DELETE_MODE:  delete_on  = cfg_wdata[0];
          btds_pkg::REG_SQUEEZE_MODE: squeeze_on = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.req_type == btds_pkg::REQ_LOAD) begin
          map_copy[in_mon.entry_index] = in_mon.entry_map;
          sel_copy[in_mon.entry_index] = in_mon.entry_selected;
        end else begin
          if (delete_on) begin
            res  = in_mon.byte_in;
            drop = sel_copy[in_mon.byte_in];
          end else begin
            res  = sel_copy[in_mon.byte_in] ? map_copy[in_mon.byte_in] : in_mon.byte_in;
            drop = squeeze_on && sel_copy[in_mon.byte_in] && have_prev && (prev_kept == res);
          end
          if (!drop) begin
            line_results_q.push_back('{byte_out: res, byte_present: 1'b1,
                                       line_end: in_mon.last_in});
            have_prev = !in_mon.last_in;
            prev_kept = in_mon.last_in ? '0 : res;
          end else if (in_mon.last_in) begin
            // A dropped final byte still closes the line with a bare result.
            line_results_q.push_back('{byte_out: '0, byte_present: 1'b0, line_end: 1'b1});
            have_prev = 1'b0;
            prev_kept = '0;
          end
        end
      end

      if (out_mon.valid && out_mon.ready) begin
        got = '{byte_out: out_mon.byte_out, byte_present: out_mon.byte_present,
                line_end: out_mon.line_end};
        if (line_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result item: byte %02h present %0b end %0b",
                     got.byte_out, got.byte_present, got.line_end);
          mismatches++;
        end else begin
          want = line_results_q.pop_front();
          if (want.byte_out !== got.byte_out || want.byte_present !== got.byte_present ||
              want.line_end !== got.line_end) begin
            if (mismatches < 10)
              $display({"result item differs: expected byte %02h present %0b end %0b,",
                        " got %02h %0b %0b"},
                       want.byte_out, want.byte_present, want.line_end,
                       got.byte_out, got.byte_present, got.line_end);
            mismatches++;
          end
        end
      end
    end
    outstanding <= line_results_q.size();
  end

endmodule

@@ verif/byte_translate_delete_squeeze_tb.sv @@
// ----------------------------------------------------------------------------
// byte_translate_delete_squeeze_tb
// Drives the translate, delete and squeeze block with table loads and lines of
// data bytes under all four mode settings, with random gaps on the input and
// random stalls on the output, and gives the verdict of the result comparator.
// ----------------------------------------------------------------------------
module byte_translate_delete_squeeze_tb;

  // The limit covers the slowest correct item, with the longest input gap and
  // output stall, several times over for all items, plus the long hold and
  // the drains between phases.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_PAD    = 8;
  localparam int unsigned RANDOM_ITEMS = 950;
  localparam int unsigned PHASE_ITEMS  = 70;
  localparam int unsigned LONG_HOLD    = 300;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [btds_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [btds_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int          mismatches;
  int          outstanding;
  int unsigned cycle_cnt = 0;
  int unsigned sent_items = 0;

  // Calm stretches switch the random idling of one side off for a while.
  bit calm_tx = 1'b0;
  bit calm_rx = 1'b0;
  // Set while the sender must offer back to back items against a held output.
  bit pressure_on = 1'b0;
  // Asks the result side to make its long hold, set by LONG_HOLD, on its next turn.
  bit long_hold_due = 1'b0;

  btds_in_if  in_ch ();
  btds_out_if out_ch ();

  byte_translate_delete_squeeze dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  btds_result_compare u_compare (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Toggle the calm stretches now and then, independently on the two sides.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) calm_tx <= ~calm_tx;
    if ($urandom_range(0, 199) == 0) calm_rx <= ~calm_rx;
  end

  // Offers one input item and returns at the edge that accepts it, after the
  // sender's gap for this item. When the gap is zero, valid simply stays high
  // so that the next call can present its item in the same time step.
  task automatic offer_item(input logic req, input logic [7:0] idx, input logic [7:0] emap,
                            input logic esel, input logic [7:0] data, input logic last);
    int unsigned gap;
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= req;
    in_ch.entry_index    <= idx;
    in_ch.entry_map      <= emap;
    in_ch.entry_selected <= esel;
    in_ch.byte_in        <= data;
    in_ch.last_in        <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_items++;
    gap = (calm_tx || pressure_on) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A table load; the data byte fields carry random noise the block ignores.
  task automatic load_entry(input logic [7:0] idx, input logic [7:0] emap, input logic esel);
    offer_item(btds_pkg::REQ_LOAD, idx, emap, esel, 8'($urandom), 1'($urandom));
  endtask

  // One data byte of a line; the load fields carry random noise.
  task automatic push_byte(input logic [7:0] data, input logic last);
    offer_item(btds_pkg::REQ_DATA, 8'($urandom), 8'($urandom), 1'($urandom), data, last);
  endtask

  // Stops offering and waits until every predicted result has been taken.
  // Dropped bytes and loads leave no prediction behind, so a further drain
  // pad lets the pipeline empty before the modes may change.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Writes the delete mode register, then the squeeze mode register; the block is idle.
  task automatic set_modes(input logic del, input logic sqz);
    cfg_we    <= 1'b1;
    cfg_index <= btds_pkg::REG_DELETE_MODE;
    cfg_wdata <= del;
    @(posedge clk);
    cfg_index <= btds_pkg::REG_SQUEEZE_MODE;
    cfg_wdata <= sqz;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly a byte close to the phase's center value, so that repeats and
  // colliding translations are common, and now and then any byte at all.
  function automatic logic [7:0] near_byte(input logic [7:0] center);
    if ($urandom_range(0, 4) == 0)
      return 8'($urandom_range(0, 255));
    return center + 8'($urandom_range(0, 3));
  endfunction

  // Result side: a random stall before each result item, or the long hold
  // when the stimulus asks for it. Ready is lowered only when a stall follows,
  // so it never gets two assignments in one time step.
  initial begin : result_sink
    int unsigned stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = calm_rx ? 0 : $urandom_range(0, 16);
        if (stall != 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned phase_end;
    int unsigned line_len;
    int unsigned k;
    logic [7:0]  center;
    logic [1:0]  mode_pick;

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= btds_pkg::REG_DELETE_MODE;
    cfg_wdata            <= '0;
    in_ch.valid          <= 1'b0;
    in_ch.req_type       <= btds_pkg::REQ_DATA;
    in_ch.entry_index    <= '0;
    in_ch.entry_map      <= '0;
    in_ch.entry_selected <= 1'b0;
    in_ch.byte_in        <= '0;
    in_ch.last_in        <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The modes start at their reset values, so the first
    // line checks the identity table and a load taking effect mid-line.
    push_byte(8'h41, 1'b0);
    load_entry(8'h61, 8'h41, 1'b1);
    push_byte(8'h61, 1'b0);
    push_byte(8'hFF, 1'b1);
    wait_idle();

    // Delete mode: a selected byte in mid-line vanishes, a selected final
    // byte leaves a bare line end.
    set_modes(1'b1, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h62, 1'b0);
    push_byte(8'h61, 1'b1);
    wait_idle();

    // Squeeze mode with the extreme table entries: a repeated selected output
    // is dropped, an unselected byte equal to the previous one is kept, the
    // line end clears the history, and a squeezed final byte is bare.
    set_modes(1'b0, 1'b1);
    load_entry(8'h00, 8'hFF, 1'b1);
    load_entry(8'hFF, 8'h00, 1'b1);
    push_byte(8'h61, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h41, 1'b1);
    push_byte(8'h61, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    wait_idle();

    // Both modes on: squeeze has nothing left to do, selected bytes drop.
    set_modes(1'b1, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h80, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7F, 1'b1);
    wait_idle();

    // Random part, in phases. Each phase starts from an idle block. All but phase
    // 5 pick the modes, seed a few table entries near their center byte and then
    // stream lines, with the odd load in the middle of a line.
    phase = 0;
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      wait_idle();
      if (phase == 5) begin
        // Fill the block against a long output hold: with both modes off
        // every data byte gives a result, so the input has to stall.
        set_modes(1'b0, 1'b0);
        pressure_on   = 1'b1;
        long_hold_due = 1'b1;
        for (k = 0; k < 48; k++)
          push_byte(8'($urandom), (k % 6) == 5);
        pressure_on = 1'b0;
      end else begin
        mode_pick = (phase < 4) ? phase[1:0] : 2'($urandom);
        set_modes(mode_pick[0], mode_pick[1]);
        center    = 8'($urandom);
        phase_end = sent_items + PHASE_ITEMS;
        repeat ($urandom_range(2, 8))
          load_entry(near_byte(center), near_byte(center), 1'($urandom_range(0, 3) != 0));
        while (sent_items < phase_end) begin
          // Mostly short lines; now and then a long one that runs on.
          line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                 : $urandom_range(1, 8);
          for (k = 0; k < line_len; k++) begin
            if ($urandom_range(0, 11) == 0)
              load_entry(near_byte(center), near_byte(center), 1'($urandom));
            push_byte(near_byte(center), k == line_len - 1);
          end
        end
      end
      phase++;
    end

    // All stimulus is in; wait for the last results and give the verdict.
    wait_idle();
    if (mismatches == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
rtl/btds_pkg.sv
rtl/btds_if.sv
rtl/btds_table.sv
rtl/byte_translate_delete_squeeze.sv
verif/btds_result_compare.sv
verif/byte_translate_delete_squeeze_tb.sv
